### src/esc_rx_pkg.sv
// Shared constants, codes and controller/datapath interface types for the escaped frame receiver.
package esc_rx_pkg;

   localparam int BUF_DEPTH_DEFAULT = 512;

   localparam logic [7:0] SYM_NUL = 8'h00;
   localparam logic [7:0] SYM_SOH = 8'h01;
   localparam logic [7:0] SYM_STX = 8'h02;
   localparam logic [7:0] SYM_ETX = 8'h03;
   localparam logic [7:0] SYM_ESC = 8'h1B;

   localparam int REQ_TDATA_W  = 24;
   localparam int REQ_TUSER_W  = 1;
   localparam int RSP_TDATA_W  = 48;
   localparam int RSP_TUSER_W  = 3;
   localparam int IDX_W        = 9;
   localparam int LEN_W        = 10;
   localparam int REQ_BYTE_LSB = 0;
   localparam int REQ_IDX_LSB  = 8;
   localparam int RSP_LEN_LSB  = 0;
   localparam int RSP_READ_LSB = 35;
   localparam int RSP_FIELDS_W = 43;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   localparam logic [RSP_TUSER_W-1:0] ST_GOOD  = 3'd0;
   localparam logic [RSP_TUSER_W-1:0] ST_CSUM  = 3'd1;
   localparam logic [RSP_TUSER_W-1:0] ST_SHORT = 3'd2;
   localparam logic [RSP_TUSER_W-1:0] ST_OVF   = 3'd3;
   localparam logic [RSP_TUSER_W-1:0] ST_READ  = 3'd4;

   localparam int MAX_FRAME_LEN = 1023;
   localparam int MIN_FRAME_LEN = 9;
   localparam int HDR_OVERHEAD  = 9;
   localparam int PAYLOAD_MAX   = 255;
   localparam int POS_FIRST     = 2;
   localparam int POS_PORT      = 2;
   localparam int POS_OPCODE    = 4;
   localparam int POS_SIZE      = 5;
   localparam int CHK_TAIL      = 3;

   typedef logic [1:0] rd_sel_type;
   localparam rd_sel_type RD_IDX  = 2'd0;
   localparam rd_sel_type RD_PREV = 2'd1;
   localparam rd_sel_type RD_WALK = 2'd2;

   typedef logic [2:0] wp_op_type;
   localparam wp_op_type WP_HOLD = 3'd0;
   localparam wp_op_type WP_ZERO = 3'd1;
   localparam wp_op_type WP_ONE  = 3'd2;
   localparam wp_op_type WP_TWO  = 3'd3;
   localparam wp_op_type WP_INC  = 3'd4;
   localparam wp_op_type WP_DEC  = 3'd5;

   typedef logic [1:0] len_op_type;
   localparam len_op_type LEN_HOLD    = 2'd0;
   localparam len_op_type LEN_POS     = 2'd1;
   localparam len_op_type LEN_POS_INC = 2'd2;

   typedef logic [1:0] out_kind_type;
   localparam out_kind_type OUT_READ  = 2'd0;
   localparam out_kind_type OUT_OVF   = 2'd1;
   localparam out_kind_type OUT_SHORT = 2'd2;
   localparam out_kind_type OUT_FRAME = 2'd3;

   typedef struct packed {
      logic         load_item;
      logic         mem_we;
      logic         rd_en;
      rd_sel_type   rd_sel;
      wp_op_type    wp_op;
      len_op_type   len_op;
      logic         walk_init;
      logic         out_load;
      out_kind_type out_kind;
   } ctl_cmd_type;

   typedef struct packed {
      logic item_read;
      logic byte_esc;
      logic byte_stx;
      logic byte_etx;
      logic byte_nul;
      logic byte_soh;
      logic wp_zero;
      logic wp_full;
      logic wp_short;
      logic prev_esc;
      logic walk_more;
      logic walk_done;
      logic csum_ok;
      logic out_busy;
   } dp_status_type;

endpackage

### src/esc_rx_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module esc_rx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### src/esc_rx_ctrl.sv
// Controller state machine for the escaped frame receiver: framing, escapes and sequencing.
module esc_rx_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  esc_rx_pkg::dp_status_type  dp_status,
   output esc_rx_pkg::ctl_cmd_type    ctl_cmd
);
   import esc_rx_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_PREV     = 3'd2;
   localparam logic [2:0] S_WALK     = 3'd3;
   localparam logic [2:0] S_EMIT     = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic         in_frame_ff, in_frame_in;
   logic         literal_ff, literal_in;
   logic         draining_ff, draining_in;
   out_kind_type kind_ff, kind_in;

   always_comb begin
      ctl_cmd          = '0;
      ctl_cmd.rd_sel   = RD_IDX;
      ctl_cmd.wp_op    = WP_HOLD;
      ctl_cmd.len_op   = LEN_HOLD;
      ctl_cmd.out_kind = kind_ff;
      req_tready       = 1'b0;
      state_in         = state_ff;
      in_frame_in      = in_frame_ff;
      literal_in       = literal_ff;
      draining_in      = draining_ff;
      kind_in          = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl_cmd.load_item = 1'b1;
               state_in          = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (dp_status.item_read) begin
               ctl_cmd.rd_en  = 1'b1;
               ctl_cmd.rd_sel = RD_IDX;
               kind_in        = OUT_READ;
               state_in       = S_EMIT;
            end else if (draining_ff) begin
               if (dp_status.byte_etx) begin
                  draining_in = 1'b0;
               end
               state_in = S_IDLE;
            end else if (!in_frame_ff) begin
               ctl_cmd.mem_we = 1'b1;
               priority if (dp_status.wp_zero) begin
                  ctl_cmd.wp_op = dp_status.byte_esc ? WP_ONE : WP_ZERO;
               end else if (dp_status.byte_stx) begin
                  in_frame_in   = 1'b1;
                  ctl_cmd.wp_op = WP_TWO;
               end else if (dp_status.byte_esc) begin
                  ctl_cmd.wp_op = WP_ONE;
               end else begin
                  ctl_cmd.wp_op = WP_ZERO;
               end
               state_in = S_IDLE;
            end else if (dp_status.wp_full) begin
               ctl_cmd.len_op = LEN_POS;
               ctl_cmd.wp_op  = WP_ZERO;
               in_frame_in    = 1'b0;
               literal_in     = 1'b0;
               kind_in        = OUT_OVF;
               state_in       = S_EMIT;
            end else if (literal_ff) begin
               ctl_cmd.mem_we = 1'b1;
               ctl_cmd.wp_op  = WP_INC;
               literal_in     = 1'b0;
               state_in       = S_IDLE;
            end else begin
               ctl_cmd.mem_we = 1'b1;
               ctl_cmd.rd_en  = 1'b1;
               ctl_cmd.rd_sel = RD_PREV;
               state_in       = S_PREV;
            end
         end
         S_PREV: begin
            state_in = S_IDLE;
            priority if (!dp_status.prev_esc) begin
               ctl_cmd.wp_op = WP_INC;
            end else if (dp_status.byte_nul) begin
               literal_in = 1'b1;
            end else if (dp_status.byte_soh) begin
               ctl_cmd.wp_op = WP_DEC;
            end else if (dp_status.byte_etx) begin
               in_frame_in       = 1'b0;
               ctl_cmd.len_op    = LEN_POS_INC;
               ctl_cmd.wp_op     = WP_ZERO;
               ctl_cmd.walk_init = 1'b1;
               if (dp_status.wp_short) begin
                  kind_in  = OUT_SHORT;
                  state_in = S_EMIT;
               end else begin
                  kind_in  = OUT_FRAME;
                  state_in = S_WALK;
               end
            end else begin
               ctl_cmd.wp_op = WP_HOLD;
            end
         end
         S_WALK: begin
            ctl_cmd.rd_en  = dp_status.walk_more;
            ctl_cmd.rd_sel = RD_WALK;
            if (dp_status.walk_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!dp_status.out_busy) begin
               ctl_cmd.out_load = 1'b1;
               if (kind_ff == OUT_FRAME && !dp_status.csum_ok) begin
                  draining_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         in_frame_ff <= 1'b0;
         literal_ff  <= 1'b0;
         draining_ff <= 1'b0;
         kind_ff     <= OUT_READ;
      end else begin
         state_ff    <= state_in;
         in_frame_ff <= in_frame_in;
         literal_ff  <= literal_in;
         draining_ff <= draining_in;
         kind_ff     <= kind_in;
      end
   end
endmodule

### src/esc_rx_datapath.sv
// Datapath of the escaped frame receiver: item registers, frame store, checksum walk and output.
module esc_rx_datapath #(
   parameter int BUF_DEPTH = esc_rx_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [esc_rx_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [esc_rx_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  esc_rx_pkg::ctl_cmd_type              ctl_cmd,
   output esc_rx_pkg::dp_status_type            dp_status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [esc_rx_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [esc_rx_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import esc_rx_pkg::*;

   localparam int AW  = $clog2(BUF_DEPTH);
   localparam int WPW = $clog2(BUF_DEPTH + 1);
   localparam int EW  = (WPW > LEN_W) ? WPW : LEN_W;

   logic                    cmd_ff;
   logic [7:0]              byte_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [WPW-1:0]          wp_ff, wp_in;
   logic [WPW-1:0]          len_ff, len_in;
   logic [AW-1:0]           walk_ptr_ff, walk_ptr_in;
   logic [7:0]              acc_ff, acc_in;
   logic                    csum_ok_ff;
   logic [7:0]              port_ff, opcode_ff, size_ff;
   logic                    rd_vld_ff, rd_vld_in;
   logic [AW-1:0]           rd_addr_ff;
   logic                    rsp_valid_ff;
   logic [RSP_TUSER_W-1:0]  rsp_user_ff, rsp_user_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [AW-1:0]           raddr;
   logic [7:0]              rdata;
   logic [WPW-1:0]          wp_m1;
   logic [WPW-1:0]          chk_pos;
   logic [WPW-1:0]          rd_addr_ext;
   logic [EW-1:0]           idx_ext;
   logic [EW-1:0]           len_ext;
   logic [EW-1:0]           payload_ext;
   logic                    in_range;
   logic                    walk_done;
   logic [LEN_W-1:0]        len_f;
   logic                    mism_f;
   logic [7:0]              port_f, opcode_f, payload_f, read_f;

   assign wp_m1       = wp_ff - 1'b1;
   assign chk_pos     = len_ff - WPW'(CHK_TAIL);
   assign rd_addr_ext = WPW'(rd_addr_ff);
   assign idx_ext     = EW'(idx_ff);
   assign in_range    = idx_ext < EW'(BUF_DEPTH);
   assign walk_done   = rd_vld_ff && (rd_addr_ext == chk_pos);
   assign rd_vld_in   = ctl_cmd.rd_en && (ctl_cmd.rd_sel == RD_WALK);

   always_comb begin
      unique case (ctl_cmd.rd_sel)
         RD_IDX:  raddr = idx_ext[AW-1:0];
         RD_PREV: raddr = wp_m1[AW-1:0];
         RD_WALK: raddr = walk_ptr_ff;
         default: raddr = '0;
      endcase
   end

   esc_rx_ram #(
      .WIDTH(8),
      .DEPTH(BUF_DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ctl_cmd.mem_we),
      .waddr(wp_ff[AW-1:0]),
      .wdata(byte_ff),
      .re   (ctl_cmd.rd_en),
      .raddr(raddr),
      .rdata(rdata)
   );

   always_comb begin
      unique case (ctl_cmd.wp_op)
         WP_HOLD: wp_in = wp_ff;
         WP_ZERO: wp_in = '0;
         WP_ONE:  wp_in = WPW'(1);
         WP_TWO:  wp_in = WPW'(2);
         WP_INC:  wp_in = wp_ff + 1'b1;
         WP_DEC:  wp_in = wp_m1;
         default: wp_in = wp_ff;
      endcase
      unique case (ctl_cmd.len_op)
         LEN_HOLD:    len_in = len_ff;
         LEN_POS:     len_in = wp_ff;
         LEN_POS_INC: len_in = wp_ff + 1'b1;
         default:     len_in = len_ff;
      endcase
      if (ctl_cmd.walk_init) begin
         walk_ptr_in = AW'(POS_FIRST);
         acc_in      = '0;
      end else begin
         walk_ptr_in = rd_vld_in ? walk_ptr_ff + 1'b1 : walk_ptr_ff;
         acc_in      = (rd_vld_ff && !walk_done) ? (acc_ff ^ rdata) : acc_ff;
      end
   end

   assign len_ext     = EW'(len_ff);
   assign payload_ext = len_ext - EW'(HDR_OVERHEAD);

   always_comb begin
      len_f       = (len_ext > EW'(MAX_FRAME_LEN)) ? LEN_W'(MAX_FRAME_LEN) : len_ext[LEN_W-1:0];
      mism_f      = 1'b0;
      port_f      = '0;
      opcode_f    = '0;
      payload_f   = '0;
      read_f      = '0;
      rsp_user_in = ST_READ;
      unique case (ctl_cmd.out_kind)
         OUT_READ: begin
            len_f  = '0;
            read_f = in_range ? rdata : 8'h00;
         end
         OUT_OVF: begin
            rsp_user_in = ST_OVF;
         end
         OUT_SHORT: begin
            rsp_user_in = ST_SHORT;
         end
         OUT_FRAME: begin
            rsp_user_in = csum_ok_ff ? ST_GOOD : ST_CSUM;
            mism_f      = EW'(size_ff) != payload_ext;
            port_f      = port_ff;
            opcode_f    = opcode_ff;
            payload_f   = (payload_ext > EW'(PAYLOAD_MAX)) ? 8'hFF : payload_ext[7:0];
         end
         default: begin
            rsp_user_in = ST_READ;
         end
      endcase
      rsp_data_in = {{RSP_PAD_W{1'b0}}, read_f, payload_f, opcode_f, port_f, mism_f, len_f};
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.load_item) begin
         cmd_ff  <= req_tuser[0];
         byte_ff <= req_tdata[REQ_BYTE_LSB +: 8];
         idx_ff  <= req_tdata[REQ_IDX_LSB +: IDX_W];
      end
      len_ff      <= len_in;
      walk_ptr_ff <= walk_ptr_in;
      acc_ff      <= acc_in;
      rd_addr_ff  <= walk_ptr_ff;
      if (walk_done) begin
         csum_ok_ff <= (acc_ff == rdata);
      end
      if (rd_vld_ff && rd_addr_ext == WPW'(POS_PORT)) begin
         port_ff <= rdata;
      end
      if (rd_vld_ff && rd_addr_ext == WPW'(POS_OPCODE)) begin
         opcode_ff <= rdata;
      end
      if (rd_vld_ff && rd_addr_ext == WPW'(POS_SIZE)) begin
         size_ff <= rdata;
      end
      if (ctl_cmd.out_load) begin
         rsp_user_ff <= rsp_user_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff     <= wp_in;
         rd_vld_ff <= rd_vld_in;
         if (ctl_cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      dp_status           = '0;
      dp_status.item_read = cmd_ff;
      dp_status.byte_esc  = byte_ff == SYM_ESC;
      dp_status.byte_stx  = byte_ff == SYM_STX;
      dp_status.byte_etx  = byte_ff == SYM_ETX;
      dp_status.byte_nul  = byte_ff == SYM_NUL;
      dp_status.byte_soh  = byte_ff == SYM_SOH;
      dp_status.wp_zero   = wp_ff == '0;
      dp_status.wp_full   = wp_ff == WPW'(BUF_DEPTH);
      dp_status.wp_short  = wp_ff < WPW'(MIN_FRAME_LEN - 1);
      dp_status.prev_esc  = rdata == SYM_ESC;
      dp_status.walk_more = WPW'(walk_ptr_ff) <= chk_pos;
      dp_status.walk_done = walk_done;
      dp_status.csum_ok   = csum_ok_ff;
      dp_status.out_busy  = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

### src/escaped_frame_receiver.sv
// Top level of the escaped frame receiver: controller, datapath and frame store.
//
// The req channel carries one word per serial byte or read command. A serial byte is
// unstuffed into the frame store; frames have the form ESC STX port id opcode size
// payload check ESC ETX. At ESC ETX the block walks the stored bytes to check the XOR
// and sends one rsp word: good or checksum error, or short frame with no walk; a frame
// that fills the store sends an overflow word instead. A read command returns the
// stored byte at read_index in one rsp word. A byte outside a frame, a byte dropped
// while discarding after a checksum error and the byte that follows ESC NUL are
// handled at dispatch; any other byte inside a frame also reads back the stored byte
// before it to spot an escape, and a read command reads the store before its result
// is sent. The checksum walk reads the store one byte per cycle.
// Only one word is in work at a time; req_tready is high only while the block waits.
// The rsp output register holds a finished result while req words are taken; a new
// result waits for rsp_tready when the register is still full.
// Reset is synchronous and returns the block to hunting for ESC STX with no result
// pending; the frame store is not cleared and needs no clearing pass.
module escaped_frame_receiver #(
   parameter int BUF_DEPTH = esc_rx_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: rx_byte[7:0], read_index[16:8], zero fill.
   input  logic [esc_rx_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0: cmd[0].
   input  logic [esc_rx_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: frame_length[9:0], size_mismatch[10], port_byte[18:11],
   // opcode_byte[26:19], payload_length[34:27], read_data[42:35], zero fill.
   output logic [esc_rx_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // Fields from bit 0: status[2:0].
   output logic [esc_rx_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import esc_rx_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   esc_rx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   esc_rx_datapath #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .ctl_cmd   (ctl_cmd),
      .dp_status (dp_status),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );
endmodule

### src/esc_rx_checker.sv
// Port-level checker for the escaped frame receiver, bound to the top level.
module esc_rx_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [esc_rx_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [esc_rx_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import esc_rx_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result word changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_READ)
      else $error("Result status out of range.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_READ |-> rsp_tdata[RSP_READ_LSB-1:0] == '0)
      else $error("Read result carries frame fields.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_SHORT
         |-> rsp_tdata[RSP_LEN_LSB +: LEN_W] < LEN_W'(MIN_FRAME_LEN))
      else $error("Short frame result with a full frame length.");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Second word accepted while one is in work.");
endmodule

bind escaped_frame_receiver esc_rx_checker u_esc_rx_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

### bench/tb_escaped_frame_receiver.sv
// Self-checking testbench for the escaped frame receiver: directed rows, then random framed traffic.
`timescale 1ns / 100ps

module tb_escaped_frame_receiver;
   import esc_rx_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int STORE_DEPTH    = BUF_DEPTH_DEFAULT;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int DRAIN_CYCLES   = 64;

   typedef struct packed {
      logic [RSP_TUSER_W-1:0] status;
      logic [LEN_W-1:0]       length;
      logic                   mism;
      logic [7:0]             port;
      logic [7:0]             opcode;
      logic [7:0]             paylen;
      logic [7:0]             rdata;
   } frame_result_type;

   typedef struct packed {
      logic                   cmd;
      logic [7:0]             rx;
      logic [IDX_W-1:0]       idx;
      logic                   fixed;
      logic [RSP_TUSER_W-1:0] st;
      logic [LEN_W-1:0]       len;
      logic [7:0]             port;
      logic [7:0]             op;
      logic [7:0]             rd;
   } stim_row_type;

   typedef enum {FLAW_NONE, FLAW_SUM, FLAW_SIZE, FLAW_CUT} flaw_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // Fields from bit 0: rx_byte[7:0], read_index[16:8], zero fill.
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // Fields from bit 0: cmd[0].
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // Fields from bit 0: frame_length[9:0], size_mismatch[10], port_byte[18:11],
   // opcode_byte[26:19], payload_length[34:27], read_data[42:35], zero fill.
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // Fields from bit 0: status[2:0].
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   logic [7:0]    fs_mem [STORE_DEPTH];
   int            fs_wr_pos;
   bit            fs_in_frame;
   bit            fs_literal;
   bit            fs_draining;
   int            fs_high = -1;

   frame_result_type pending_results [$];
   int               mismatches;
   int               n_words;
   int               seen_status [8];
   bit               calm;

   stim_row_type directed_rows [24] = '{
      '{1'b0, SYM_ESC, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_ESC, 9'h1FF, 1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_STX, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_ESC, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_ETX, 9'd0,   1'b1, ST_SHORT, 10'd4, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_ESC, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_STX, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, 8'hFF,   9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_ESC, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_NUL, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, 8'h80,   9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_ESC, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_SOH, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_ESC, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, 8'h7E,   9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_SOH, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, 8'h00,   9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, 8'h00,   9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_ESC, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_ETX, 9'd0,   1'b1, ST_CSUM,  10'd9, 8'hFF, 8'h80, 8'h00},
      '{1'b0, 8'h41,   9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b0, SYM_ETX, 9'd0,   1'b0, ST_GOOD,  10'd0, 8'h00, 8'h00, 8'h00},
      '{1'b1, 8'h00,   9'd3,   1'b1, ST_READ,  10'd0, 8'h00, 8'h00, SYM_ESC},
      '{1'b1, 8'hFF,   9'd2,   1'b1, ST_READ,  10'd0, 8'h00, 8'h00, 8'hFF}
   };

   escaped_frame_receiver #(
      .BUF_DEPTH(STORE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [7:0] store_get(int i);
      return (i >= 0 && i < STORE_DEPTH) ? fs_mem[i] : 8'h00;
   endfunction

   function automatic void store_put(int i, logic [7:0] v);
      if (i < STORE_DEPTH) begin
         fs_mem[i] = v;
         if (i > fs_high) fs_high = i;
      end
   endfunction

   function automatic frame_result_type close_frame(int len);
      frame_result_type r;
      logic [7:0]       x;
      int               pay;
      r = '0;
      r.length = (len > MAX_FRAME_LEN) ? LEN_W'(MAX_FRAME_LEN) : LEN_W'(len);
      if (len < MIN_FRAME_LEN) begin
         r.status = ST_SHORT;
         return r;
      end
      pay = len - HDR_OVERHEAD;
      x = 8'h00;
      for (int i = POS_FIRST; i + CHK_TAIL < len; i++) x ^= store_get(i);
      r.status = (x == store_get(len - CHK_TAIL)) ? ST_GOOD : ST_CSUM;
      r.mism   = (int'(store_get(POS_SIZE)) != pay);
      r.port   = store_get(POS_PORT);
      r.opcode = store_get(POS_OPCODE);
      r.paylen = (pay > PAYLOAD_MAX) ? 8'(PAYLOAD_MAX) : 8'(pay);
      if (r.status == ST_CSUM) fs_draining = 1'b1;
      return r;
   endfunction

   task automatic predict_word(input logic cmd, input logic [7:0] rx,
                               input logic [IDX_W-1:0] idx,
                               output bit has, output frame_result_type r);
      int p;
      p = fs_wr_pos;
      r = '0;
      has = 1'b0;
      if (cmd) begin
         has = 1'b1;
         r.status = ST_READ;
         r.rdata = store_get(idx);
         return;
      end
      if (fs_draining) begin
         if (rx == SYM_ETX) fs_draining = 1'b0;
         return;
      end
      if (!fs_in_frame) begin
         if (p == 0) begin
            store_put(0, rx);
            fs_wr_pos = (rx == SYM_ESC) ? 1 : 0;
         end else begin
            store_put(1, rx);
            if (rx == SYM_STX) begin
               fs_in_frame = 1'b1;
               fs_wr_pos = 2;
            end else begin
               fs_wr_pos = (rx == SYM_ESC) ? 1 : 0;
            end
         end
         return;
      end
      if (p >= STORE_DEPTH) begin
         has = 1'b1;
         r.status = ST_OVF;
         r.length = LEN_W'(p);
         fs_in_frame = 1'b0;
         fs_literal = 1'b0;
         fs_wr_pos = 0;
         return;
      end
      store_put(p, rx);
      if (fs_literal) begin
         fs_literal = 1'b0;
         fs_wr_pos = p + 1;
         return;
      end
      if (p >= 1 && store_get(p - 1) == SYM_ESC) begin
         if (rx == SYM_NUL) begin
            fs_literal = 1'b1;
         end else if (rx == SYM_SOH) begin
            fs_wr_pos = p - 1;
         end else if (rx == SYM_ETX) begin
            fs_in_frame = 1'b0;
            fs_wr_pos = 0;
            r = close_frame(p + 1);
            has = 1'b1;
         end
         return;
      end
      fs_wr_pos = p + 1;
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("MISMATCH at %0t ns: %s is %0h, expected %0h", $time, field, got, want);
      mismatches++;
   endtask

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic drive_word(input logic cmd, input logic [7:0] rx,
                             input logic [IDX_W-1:0] idx,
                             input bit fixed, input frame_result_type want);
      bit               has;
      frame_result_type r;
      calm = (n_words >= 300 && n_words < 500);
      while (!calm && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, idx, rx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(cmd, rx, idx, has, r);
      if (has) pending_results.push_back(fixed ? want : r);
      n_words++;
      @(negedge clock);
   endtask

   task automatic send_read(input int idx);
      drive_word(1'b1, 8'($urandom_range(0, 255)), IDX_W'(idx), 1'b0, '0);
   endtask

   task automatic send_byte(input logic [7:0] rx);
      if (fs_high >= 0 && $urandom_range(0, 99) < 8) send_read($urandom_range(0, fs_high));
      drive_word(1'b0, rx, IDX_W'($urandom_range(0, 511)), 1'b0, '0);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [7:0] pick_rx();
      logic [7:0] codes [5] = '{SYM_ESC, SYM_NUL, SYM_SOH, SYM_STX, SYM_ETX};
      if ($urandom_range(0, 7) == 0) return codes[$urandom_range(0, 4)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_frame(input int pay_n, input flaw_type flaw);
      logic [7:0] body [$];
      logic [7:0] chk;
      logic [7:0] sz;
      int         i;
      int         keep;
      sz = 8'(pay_n);
      if (flaw == FLAW_SIZE) sz ^= 8'($urandom_range(1, 255));
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(pick_rx());
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(sz);
      repeat (pay_n) body.push_back(pick_rx());
      // A byte carried after ESC NUL must not itself be ESC, or it would open an escape.
      i = 0;
      while (i + 1 < body.size()) begin
         if (body[i] == SYM_ESC) begin
            if (body[i + 1] == SYM_ESC) body[i + 1] = SYM_ESC ^ 8'h01;
            i += 2;
         end else begin
            i++;
         end
      end
      chk = 8'h00;
      foreach (body[k]) chk ^= body[k];
      if (flaw == FLAW_SUM) chk ^= 8'($urandom_range(1, 255));
      body.push_back(chk);
      if (flaw == FLAW_CUT) begin
         keep = $urandom_range(0, 4);
         while (body.size() > keep) void'(body.pop_back());
      end
      send_byte(SYM_ESC);
      send_byte(SYM_STX);
      i = 0;
      while (i < body.size()) begin
         if ($urandom_range(0, 15) == 0) begin
            send_byte(SYM_ESC);
            if ($urandom_range(0, 1)) send_byte(8'($urandom_range(4, 255)));
            send_byte(SYM_SOH);
         end
         if (body[i] == SYM_ESC) begin
            send_byte(SYM_ESC);
            send_byte(SYM_NUL);
            if (i + 1 < body.size()) send_byte(body[i + 1]);
            i += 2;
         end else begin
            send_byte(body[i]);
            i++;
         end
      end
      send_byte(SYM_ESC);
      send_byte(SYM_ETX);
      if (flaw == FLAW_SUM && $urandom_range(0, 9) < 7) begin
         repeat ($urandom_range(0, 3)) send_byte(pick_rx());
         send_byte(SYM_ETX);
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 20);
   end

   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.length = rsp_tdata[RSP_LEN_LSB +: LEN_W];
         got.mism   = rsp_tdata[10];
         got.port   = rsp_tdata[18:11];
         got.opcode = rsp_tdata[26:19];
         got.paylen = rsp_tdata[34:27];
         got.rdata  = rsp_tdata[RSP_READ_LSB +: 8];
         seen_status[got.status]++;
         if (pending_results.size() == 0) begin
            report_mismatch("status of unexpected word", got.status, 0);
         end else begin
            want = pending_results.pop_front();
            if (got.status != want.status) report_mismatch("status", got.status, want.status);
            if (got.length != want.length) report_mismatch("frame_length", got.length, want.length);
            if (got.mism != want.mism) report_mismatch("size_mismatch", got.mism, want.mism);
            if (got.port != want.port) report_mismatch("port_byte", got.port, want.port);
            if (got.opcode != want.opcode) report_mismatch("opcode_byte", got.opcode, want.opcode);
            if (got.paylen != want.paylen) report_mismatch("payload_length", got.paylen, want.paylen);
            if (got.rdata != want.rdata) report_mismatch("read_data", got.rdata, want.rdata);
         end
      end
   end

   initial begin
      stim_row_type     row;
      frame_result_type want;
      int               frame_no;
      int               roll;
      flaw_type         flaw;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         want = '0;
         want.status = row.st;
         want.length = row.len;
         want.port   = row.port;
         want.opcode = row.op;
         want.rdata  = row.rd;
         drive_word(row.cmd, row.rx, row.idx, row.fixed, want);
      end
      wait_for_results();

      frame_no = 0;
      while (n_words < 1000 || frame_no < 8) begin
         if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 3)) send_byte(pick_rx());
         roll = $urandom_range(0, 99);
         flaw = (roll < 60) ? FLAW_NONE : (roll < 75) ? FLAW_SUM : (roll < 85) ? FLAW_SIZE : FLAW_CUT;
         case (frame_no)
            2: begin
               send_frame(STORE_DEPTH - HDR_OVERHEAD, FLAW_NONE);
            end
            4: begin
               send_frame(STORE_DEPTH + 3, FLAW_NONE);
               send_read(STORE_DEPTH - 1);
               send_read(0);
            end
            default: begin
               send_frame($urandom_range(0, 12), flaw);
            end
         endcase
         if (frame_no == 5) wait_for_results();
         frame_no++;
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Run covered %0d request words: %0d good frames, %0d checksum errors,",
               n_words, seen_status[ST_GOOD], seen_status[ST_CSUM]);
      $display("%0d short frames, %0d overflows and %0d reads, up to a completely full store.",
               seen_status[ST_SHORT], seen_status[ST_OVF], seen_status[ST_READ]);
      if (mismatches == 0) begin
         $display("tb_escaped_frame_receiver: PASS");
      end else begin
         $display("tb_escaped_frame_receiver: FAIL");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Timeout with %0d results still expected.", pending_results.size());
      $display("tb_escaped_frame_receiver: FAIL");
      $finish;
   end

endmodule

### escaped_frame_receiver.f
src/esc_rx_pkg.sv
src/esc_rx_ram.sv
src/esc_rx_ctrl.sv
src/esc_rx_datapath.sv
src/escaped_frame_receiver.sv
src/esc_rx_checker.sv
bench/tb_escaped_frame_receiver.sv
